>>> sv/acmp_cr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACMP connection responder package
// Message codes, notify codes, register indexes and field widths shared by
// the responder and its checker.
// ----------------------------------------------------------------------------
package acmp_cr_pkg;

    localparam int MAC_W    = 48;
    localparam int ID_W     = 64;
    localparam int COUNT_W  = 16;
    localparam int FLEN_W   = 11;
    localparam int MSG_W    = 4;
    localparam int STATUS_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0]        ACMP_SUBTYPE  = 8'h7C;
    // 14 byte Ethernet header plus a 56 byte ACMPDU
    localparam logic [FLEN_W-1:0] MIN_FRM_BYTES = 11'd70;

    typedef logic [MSG_W-1:0] t_msg;

    localparam t_msg MSG_CONNECT_TX    = 4'd0;
    localparam t_msg MSG_DISCONNECT_TX = 4'd2;
    localparam t_msg MSG_GET_TX_STATE  = 4'd4;
    localparam t_msg MSG_CONNECT_RX    = 4'd6;
    localparam t_msg MSG_DISCONNECT_RX = 4'd8;
    localparam t_msg MSG_GET_RX_STATE  = 4'd10;

    typedef logic [2:0] t_notify;

    localparam t_notify NOTIFY_NONE          = 3'd0;
    localparam t_notify NOTIFY_TX_CONNECT    = 3'd1;
    localparam t_notify NOTIFY_TX_DISCONNECT = 3'd2;
    localparam t_notify NOTIFY_RX_CONNECT    = 3'd3;
    localparam t_notify NOTIFY_RX_DISCONNECT = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_SUCCESS = 5'd0;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENTITY_MAC  = 2'd0;
    localparam t_cfg_idx CFG_OWN_STRM_ID = 2'd1;
    localparam t_cfg_idx CFG_OWN_DST_MAC = 2'd2;

endpackage

>>> sv/acmp_connection_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACMP connection responder
// Checks parsed ACMP commands against the own entity id, keeps talker and
// listener connection state and returns one success response per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one parsed AVTP PDU per
//   word. PDUs with the wrong subtype, a short frame, a non-command message
//   type or a foreign entity id produce no response word.
//   Output channel (o_out_valid / i_out_stall) carries one response word per
//   matching command, with the connection state as it stands after it.
//   Configuration (i_cfg_valid / o_cfg_ready) writes entity MAC, own stream
//   id and own stream destination MAC; ready is always high. Write only while
//   the block is idle.
//   Throughput: one word per cycle unless the output stalls. A word passes
//   the input register and then the response register; state is updated as
//   a word leaves the input register, so the next word sees it at once.
//   Reset clears both stages, all connection state and the registers.
//   When the receiver stalls, the response register holds; the input
//   register still drains words that give no response, and a word that does
//   waits, which stalls the input side.
// ----------------------------------------------------------------------------
module acmp_connection_responder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [acmp_cr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                         i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [acmp_cr_pkg::FLEN_W-1:0]      i_frm_bytes,
    input  logic [7:0]                          i_subtype,
    input  logic [acmp_cr_pkg::MSG_W-1:0]       i_msg_code,
    input  logic [acmp_cr_pkg::ID_W-1:0]        i_strm_id_in,
    input  logic [acmp_cr_pkg::ID_W-1:0]        i_tlk_id_in,
    input  logic [acmp_cr_pkg::ID_W-1:0]        i_lsn_id_in,
    input  logic [acmp_cr_pkg::MAC_W-1:0]       i_dst_mac_in,
    input  logic [acmp_cr_pkg::COUNT_W-1:0]     i_conn_count_in,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [acmp_cr_pkg::MSG_W-1:0]       o_resp_msg_code,
    output logic [acmp_cr_pkg::STATUS_W-1:0]    o_resp_status,
    output logic [acmp_cr_pkg::ID_W-1:0]        o_resp_strm_id,
    output logic [acmp_cr_pkg::MAC_W-1:0]       o_resp_dst_mac,
    output logic [acmp_cr_pkg::COUNT_W-1:0]     o_resp_conn_count,
    output logic [2:0]                          o_notify_event,
    output logic                                o_talker_is_connected,
    output logic                                o_listener_is_connected,
    output logic [acmp_cr_pkg::ID_W-1:0]        o_peer_lsn_id,
    output logic [acmp_cr_pkg::ID_W-1:0]        o_bound_tlk_id,
    output logic [acmp_cr_pkg::ID_W-1:0]        o_bound_strm_id,
    output logic [acmp_cr_pkg::MAC_W-1:0]       o_bound_dst_mac
);

    // configuration
    logic [acmp_cr_pkg::MAC_W-1:0]   r_entity_mac;
    logic [acmp_cr_pkg::ID_W-1:0]    r_own_strm_id;
    logic [acmp_cr_pkg::MAC_W-1:0]   r_own_dst_mac;

    // input register
    logic                            r_s1_valid;
    logic [acmp_cr_pkg::FLEN_W-1:0]  r_s1_frm_bytes;
    logic [7:0]                      r_s1_subtype;
    acmp_cr_pkg::t_msg               r_s1_msg_code;
    logic [acmp_cr_pkg::ID_W-1:0]    r_s1_strm_id;
    logic [acmp_cr_pkg::ID_W-1:0]    r_s1_tlk_id;
    logic [acmp_cr_pkg::ID_W-1:0]    r_s1_lsn_id;
    logic [acmp_cr_pkg::MAC_W-1:0]   r_s1_dst_mac;
    logic [acmp_cr_pkg::COUNT_W-1:0] r_s1_conn_count;

    // connection state
    logic                            r_talker_on;
    logic [acmp_cr_pkg::COUNT_W-1:0] r_talker_count;
    logic [acmp_cr_pkg::ID_W-1:0]    r_talker_peer;
    logic                            r_listener_on;
    logic [acmp_cr_pkg::COUNT_W-1:0] r_listener_count;
    logic [acmp_cr_pkg::ID_W-1:0]    r_listener_peer;
    logic [acmp_cr_pkg::ID_W-1:0]    r_listener_stream;
    logic [acmp_cr_pkg::MAC_W-1:0]   r_listener_mac;

    logic                            n_talker_on;
    logic [acmp_cr_pkg::COUNT_W-1:0] n_talker_count;
    logic [acmp_cr_pkg::ID_W-1:0]    n_talker_peer;
    logic                            n_listener_on;
    logic [acmp_cr_pkg::COUNT_W-1:0] n_listener_count;
    logic [acmp_cr_pkg::ID_W-1:0]    n_listener_peer;
    logic [acmp_cr_pkg::ID_W-1:0]    n_listener_stream;
    logic [acmp_cr_pkg::MAC_W-1:0]   n_listener_mac;

    // response register
    logic                            r_out_valid;
    acmp_cr_pkg::t_msg               r_resp_msg_code;
    logic [acmp_cr_pkg::ID_W-1:0]    r_resp_strm_id;
    logic [acmp_cr_pkg::MAC_W-1:0]   r_resp_dst_mac;
    logic [acmp_cr_pkg::COUNT_W-1:0] r_resp_conn_count;
    acmp_cr_pkg::t_notify            r_notify_event;

    acmp_cr_pkg::t_notify            n_notify;
    logic [acmp_cr_pkg::ID_W-1:0]    n_resp_strm_id;
    logic [acmp_cr_pkg::MAC_W-1:0]   n_resp_dst_mac;
    logic [acmp_cr_pkg::COUNT_W-1:0] n_resp_conn_count;

    logic [acmp_cr_pkg::ID_W-1:0]    own_id;
    logic                            pdu_ok;
    logic                            cmd_ok;
    logic                            is_tx;
    logic                            id_match;
    logic                            s1_emit;
    logic                            out_free;
    logic                            s1_fire;
    logic                            s1_free;
    logic                            upd_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entity_mac  <= '0;
            r_own_strm_id <= '0;
            r_own_dst_mac <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acmp_cr_pkg::CFG_ENTITY_MAC:  r_entity_mac  <= i_cfg_data[acmp_cr_pkg::MAC_W-1:0];
                acmp_cr_pkg::CFG_OWN_STRM_ID: r_own_strm_id <= i_cfg_data;
                acmp_cr_pkg::CFG_OWN_DST_MAC: r_own_dst_mac <= i_cfg_data[acmp_cr_pkg::MAC_W-1:0];
                default: ;
            endcase
        end
    end

    // --- stage 1 decode ---
    assign own_id   = {r_entity_mac, 16'h0000};
    assign pdu_ok   = (r_s1_subtype == acmp_cr_pkg::ACMP_SUBTYPE)
                      && (r_s1_frm_bytes >= acmp_cr_pkg::MIN_FRM_BYTES);
    assign cmd_ok   = !r_s1_msg_code[0] && (r_s1_msg_code <= acmp_cr_pkg::MSG_GET_RX_STATE);
    assign is_tx    = (r_s1_msg_code <= acmp_cr_pkg::MSG_GET_TX_STATE);
    assign id_match = is_tx ? (r_s1_tlk_id == own_id) : (r_s1_lsn_id == own_id);
    assign s1_emit  = pdu_ok && cmd_ok && id_match;

    // dropped words leave the input register even while the output is held
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (out_free || !s1_emit);
    assign s1_free    = !r_s1_valid || s1_fire;
    assign o_in_stall = !s1_free;
    assign upd_en     = s1_fire && s1_emit;

    always_comb begin
        n_talker_on       = r_talker_on;
        n_talker_count    = r_talker_count;
        n_talker_peer     = r_talker_peer;
        n_listener_on     = r_listener_on;
        n_listener_count  = r_listener_count;
        n_listener_peer   = r_listener_peer;
        n_listener_stream = r_listener_stream;
        n_listener_mac    = r_listener_mac;
        n_notify          = acmp_cr_pkg::NOTIFY_NONE;
        unique case (r_s1_msg_code)
            acmp_cr_pkg::MSG_CONNECT_TX: begin
                n_talker_peer  = r_s1_lsn_id;
                n_talker_on    = 1'b1;
                n_talker_count = r_talker_count + 1'b1;
                n_notify       = acmp_cr_pkg::NOTIFY_TX_CONNECT;
            end
            acmp_cr_pkg::MSG_DISCONNECT_TX: begin
                n_talker_on = 1'b0;
                // floor at zero
                if (r_talker_count != '0) begin
                    n_talker_count = r_talker_count - 1'b1;
                end
                n_notify = acmp_cr_pkg::NOTIFY_TX_DISCONNECT;
            end
            acmp_cr_pkg::MSG_CONNECT_RX: begin
                n_listener_peer   = r_s1_tlk_id;
                n_listener_stream = r_s1_strm_id;
                n_listener_mac    = r_s1_dst_mac;
                n_listener_on     = 1'b1;
                n_listener_count  = r_listener_count + 1'b1;
                n_notify          = acmp_cr_pkg::NOTIFY_RX_CONNECT;
            end
            acmp_cr_pkg::MSG_DISCONNECT_RX: begin
                n_listener_on = 1'b0;
                if (r_listener_count != '0) begin
                    n_listener_count = r_listener_count - 1'b1;
                end
                n_notify = acmp_cr_pkg::NOTIFY_RX_DISCONNECT;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_resp_strm_id    = r_s1_strm_id;
        n_resp_dst_mac    = r_s1_dst_mac;
        n_resp_conn_count = r_s1_conn_count;
        if (r_s1_msg_code == acmp_cr_pkg::MSG_CONNECT_TX
            || r_s1_msg_code == acmp_cr_pkg::MSG_GET_TX_STATE) begin
            n_resp_strm_id    = r_own_strm_id;
            n_resp_dst_mac    = r_own_dst_mac;
            n_resp_conn_count = n_talker_count;
        end else if (r_s1_msg_code == acmp_cr_pkg::MSG_CONNECT_RX
                     || r_s1_msg_code == acmp_cr_pkg::MSG_GET_RX_STATE) begin
            n_resp_conn_count = n_listener_count;
        end
    end

    // --- control registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= upd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_talker_on       <= 1'b0;
            r_talker_count    <= '0;
            r_talker_peer     <= '0;
            r_listener_on     <= 1'b0;
            r_listener_count  <= '0;
            r_listener_peer   <= '0;
            r_listener_stream <= '0;
            r_listener_mac    <= '0;
        end else if (upd_en) begin
            r_talker_on       <= n_talker_on;
            r_talker_count    <= n_talker_count;
            r_talker_peer     <= n_talker_peer;
            r_listener_on     <= n_listener_on;
            r_listener_count  <= n_listener_count;
            r_listener_peer   <= n_listener_peer;
            r_listener_stream <= n_listener_stream;
            r_listener_mac    <= n_listener_mac;
        end
    end

    // --- payload registers ---
    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1_frm_bytes  <= i_frm_bytes;
            r_s1_subtype    <= i_subtype;
            r_s1_msg_code   <= i_msg_code;
            r_s1_strm_id    <= i_strm_id_in;
            r_s1_tlk_id     <= i_tlk_id_in;
            r_s1_lsn_id     <= i_lsn_id_in;
            r_s1_dst_mac    <= i_dst_mac_in;
            r_s1_conn_count <= i_conn_count_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_en) begin
            r_resp_msg_code   <= r_s1_msg_code + 1'b1;
            r_resp_strm_id    <= n_resp_strm_id;
            r_resp_dst_mac    <= n_resp_dst_mac;
            r_resp_conn_count <= n_resp_conn_count;
            r_notify_event    <= n_notify;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_resp_msg_code         = r_resp_msg_code;
    assign o_resp_status           = acmp_cr_pkg::STATUS_SUCCESS;
    assign o_resp_strm_id          = r_resp_strm_id;
    assign o_resp_dst_mac          = r_resp_dst_mac;
    assign o_resp_conn_count       = r_resp_conn_count;
    assign o_notify_event          = r_notify_event;
    // state only changes when a response is loaded, so it matches the held word
    assign o_talker_is_connected   = r_talker_on;
    assign o_listener_is_connected = r_listener_on;
    assign o_peer_lsn_id           = r_talker_peer;
    assign o_bound_tlk_id          = r_listener_peer;
    assign o_bound_strm_id         = r_listener_stream;
    assign o_bound_dst_mac         = r_listener_mac;

endmodule

>>> sv/acmp_cr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACMP connection responder checker
// Port-level checks on response words, bound to the responder.
// ----------------------------------------------------------------------------
module acmp_cr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [acmp_cr_pkg::MSG_W-1:0]       o_resp_msg_code,
    input  logic [acmp_cr_pkg::STATUS_W-1:0]    o_resp_status,
    input  logic [2:0]                          o_notify_event,
    input  logic                                o_talker_is_connected,
    input  logic                                o_listener_is_connected
);

    // hold a stalled response word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_resp_msg_code)
                                       && $stable(o_notify_event))
        else $error("response word changed while stalled");

    // responses always answer an even command code
    a_odd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_resp_msg_code[0]
                        && o_resp_status == acmp_cr_pkg::STATUS_SUCCESS)
        else $error("bad response code or status");

    a_tx_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_notify_event == acmp_cr_pkg::NOTIFY_TX_CONNECT
        |-> o_talker_is_connected
            && o_resp_msg_code == acmp_cr_pkg::MSG_CONNECT_TX + 4'd1)
        else $error("talker connect without talker connected");

    a_rx_disconnect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_notify_event == acmp_cr_pkg::NOTIFY_RX_DISCONNECT
        |-> !o_listener_is_connected
            && o_resp_msg_code == acmp_cr_pkg::MSG_DISCONNECT_RX + 4'd1)
        else $error("listener disconnect left listener connected");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

endmodule

bind acmp_connection_responder acmp_cr_checker u_acmp_cr_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_out_valid             (o_out_valid),
    .i_out_stall             (i_out_stall),
    .o_resp_msg_code         (o_resp_msg_code),
    .o_resp_status           (o_resp_status),
    .o_notify_event          (o_notify_event),
    .o_talker_is_connected   (o_talker_is_connected),
    .o_listener_is_connected (o_listener_is_connected)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACMP connection responder testbench
// Feeds parsed PDUs through the valid/stall input channel with random gaps,
// stalls the response channel at random and checks every response word,
// field by field, against a cycle-free model of the talker and listener
// connection state. Runs a directed set and several random phases under
// different register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_GAP       = 11;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PDUS    = 70;
    localparam acmp_cr_pkg::t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [acmp_cr_pkg::FLEN_W-1:0]  frm_bytes;
        logic [7:0]                      subtype;
        acmp_cr_pkg::t_msg               msg_code;
        logic [acmp_cr_pkg::ID_W-1:0]    strm_id;
        logic [acmp_cr_pkg::ID_W-1:0]    tlk_id;
        logic [acmp_cr_pkg::ID_W-1:0]    lsn_id;
        logic [acmp_cr_pkg::MAC_W-1:0]   dst_mac;
        logic [acmp_cr_pkg::COUNT_W-1:0] conn_count;
    } t_pdu;

    typedef struct packed {
        acmp_cr_pkg::t_msg                msg_code;
        logic [acmp_cr_pkg::STATUS_W-1:0] status;
        logic [acmp_cr_pkg::ID_W-1:0]     strm_id;
        logic [acmp_cr_pkg::MAC_W-1:0]    dst_mac;
        logic [acmp_cr_pkg::COUNT_W-1:0]  conn_count;
        acmp_cr_pkg::t_notify             notify;
        logic                             talker_on;
        logic                             listener_on;
        logic [acmp_cr_pkg::ID_W-1:0]     peer_listener;
        logic [acmp_cr_pkg::ID_W-1:0]     bound_talker;
        logic [acmp_cr_pkg::ID_W-1:0]     bound_stream;
        logic [acmp_cr_pkg::MAC_W-1:0]    bound_mac;
    } t_resp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [acmp_cr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]                       i_cfg_data  = '0;

    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [acmp_cr_pkg::FLEN_W-1:0]    i_frm_bytes;
    logic [7:0]                        i_subtype;
    logic [acmp_cr_pkg::MSG_W-1:0]     i_msg_code;
    logic [acmp_cr_pkg::ID_W-1:0]      i_strm_id_in;
    logic [acmp_cr_pkg::ID_W-1:0]      i_tlk_id_in;
    logic [acmp_cr_pkg::ID_W-1:0]      i_lsn_id_in;
    logic [acmp_cr_pkg::MAC_W-1:0]     i_dst_mac_in;
    logic [acmp_cr_pkg::COUNT_W-1:0]   i_conn_count_in;

    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [acmp_cr_pkg::MSG_W-1:0]     o_resp_msg_code;
    logic [acmp_cr_pkg::STATUS_W-1:0]  o_resp_status;
    logic [acmp_cr_pkg::ID_W-1:0]      o_resp_strm_id;
    logic [acmp_cr_pkg::MAC_W-1:0]     o_resp_dst_mac;
    logic [acmp_cr_pkg::COUNT_W-1:0]   o_resp_conn_count;
    logic [2:0]                        o_notify_event;
    logic                              o_talker_is_connected;
    logic                              o_listener_is_connected;
    logic [acmp_cr_pkg::ID_W-1:0]      o_peer_lsn_id;
    logic [acmp_cr_pkg::ID_W-1:0]      o_bound_tlk_id;
    logic [acmp_cr_pkg::ID_W-1:0]      o_bound_strm_id;
    logic [acmp_cr_pkg::MAC_W-1:0]     o_bound_dst_mac;

    // PDU on the input channel, held while stalled
    t_pdu        cur_pdu = '0;
    t_pdu        pdu_queue[$];
    t_resp       resp_expected[$];
    int unsigned pdu_pushed   = 0;
    int unsigned pdu_taken    = 0;
    int unsigned in_gap       = 0;
    int unsigned out_hold     = 0;
    logic        in_accepted  = 1'b0;
    logic        out_accepted = 1'b0;
    logic        idle_on      = 1'b1;
    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;

    // register copies
    logic [acmp_cr_pkg::MAC_W-1:0] cfg_mac     = '0;
    logic [acmp_cr_pkg::ID_W-1:0]  cfg_strm_id = '0;
    logic [acmp_cr_pkg::MAC_W-1:0] cfg_dst_mac = '0;

    // connection state
    logic                            tx_linked = 1'b0;
    logic [acmp_cr_pkg::COUNT_W-1:0] tx_count  = '0;
    logic [acmp_cr_pkg::ID_W-1:0]    tx_peer   = '0;
    logic                            rx_linked = 1'b0;
    logic [acmp_cr_pkg::COUNT_W-1:0] rx_count  = '0;
    logic [acmp_cr_pkg::ID_W-1:0]    rx_talker = '0;
    logic [acmp_cr_pkg::ID_W-1:0]    rx_stream = '0;
    logic [acmp_cr_pkg::MAC_W-1:0]   rx_mac    = '0;

    assign i_frm_bytes     = cur_pdu.frm_bytes;
    assign i_subtype       = cur_pdu.subtype;
    assign i_msg_code      = cur_pdu.msg_code;
    assign i_strm_id_in    = cur_pdu.strm_id;
    assign i_tlk_id_in     = cur_pdu.tlk_id;
    assign i_lsn_id_in     = cur_pdu.lsn_id;
    assign i_dst_mac_in    = cur_pdu.dst_mac;
    assign i_conn_count_in = cur_pdu.conn_count;

    acmp_connection_responder dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_frm_bytes             (i_frm_bytes),
        .i_subtype               (i_subtype),
        .i_msg_code              (i_msg_code),
        .i_strm_id_in            (i_strm_id_in),
        .i_tlk_id_in             (i_tlk_id_in),
        .i_lsn_id_in             (i_lsn_id_in),
        .i_dst_mac_in            (i_dst_mac_in),
        .i_conn_count_in         (i_conn_count_in),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_resp_msg_code         (o_resp_msg_code),
        .o_resp_status           (o_resp_status),
        .o_resp_strm_id          (o_resp_strm_id),
        .o_resp_dst_mac          (o_resp_dst_mac),
        .o_resp_conn_count       (o_resp_conn_count),
        .o_notify_event          (o_notify_event),
        .o_talker_is_connected   (o_talker_is_connected),
        .o_listener_is_connected (o_listener_is_connected),
        .o_peer_lsn_id           (o_peer_lsn_id),
        .o_bound_tlk_id          (o_bound_tlk_id),
        .o_bound_strm_id         (o_bound_strm_id),
        .o_bound_dst_mac         (o_bound_dst_mac)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [acmp_cr_pkg::ID_W-1:0] own_entity_id();
        return {cfg_mac, 16'h0000};
    endfunction

    function automatic int unsigned draw_gap();
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // well-formed command addressed to this entity, random content elsewhere
    function automatic t_pdu command_pdu(acmp_cr_pkg::t_msg code);
        t_pdu p;
        p.frm_bytes  = 11'($urandom_range(acmp_cr_pkg::MIN_FRM_BYTES, 2047));
        p.subtype    = acmp_cr_pkg::ACMP_SUBTYPE;
        p.msg_code   = code;
        p.strm_id    = rand64();
        p.tlk_id     = rand64();
        p.lsn_id     = rand64();
        p.dst_mac    = 48'(rand64());
        p.conn_count = 16'($urandom);
        if (code <= acmp_cr_pkg::MSG_GET_TX_STATE) begin
            p.tlk_id = own_entity_id();
        end else begin
            p.lsn_id = own_entity_id();
        end
        return p;
    endfunction

    function automatic acmp_cr_pkg::t_msg pick_command();
        case ($urandom_range(0, 5))
            0:       return acmp_cr_pkg::MSG_CONNECT_TX;
            1:       return acmp_cr_pkg::MSG_DISCONNECT_TX;
            2:       return acmp_cr_pkg::MSG_GET_TX_STATE;
            3:       return acmp_cr_pkg::MSG_CONNECT_RX;
            4:       return acmp_cr_pkg::MSG_DISCONNECT_RX;
            default: return acmp_cr_pkg::MSG_GET_RX_STATE;
        endcase
    endfunction

    function automatic t_pdu random_pdu();
        t_pdu p;
        if ($urandom_range(0, 99) < 75) begin
            p = command_pdu(pick_command());
        end else begin
            p = command_pdu(acmp_cr_pkg::t_msg'($urandom_range(0, 15)));
            case ($urandom_range(0, 3))
                0: p.subtype = 8'($urandom);
                1: p.frm_bytes = 11'($urandom_range(0, 2047));
                2: begin
                    p.tlk_id = rand64();
                    p.lsn_id = rand64();
                end
                default: ;
            endcase
        end
        return p;
    endfunction

    task automatic push_pdu(t_pdu p);
        pdu_queue.push_back(p);
        pdu_pushed++;
    endtask

    task automatic predict_response(input t_pdu p);
        t_resp r;
        logic  addressed;
        addressed = (p.msg_code <= acmp_cr_pkg::MSG_GET_TX_STATE)
                    ? (p.tlk_id == own_entity_id()) : (p.lsn_id == own_entity_id());
        if (p.subtype == acmp_cr_pkg::ACMP_SUBTYPE
            && p.frm_bytes >= acmp_cr_pkg::MIN_FRM_BYTES && !p.msg_code[0]
            && p.msg_code <= acmp_cr_pkg::MSG_GET_RX_STATE && addressed) begin
            r.notify     = acmp_cr_pkg::NOTIFY_NONE;
            r.strm_id    = p.strm_id;
            r.dst_mac    = p.dst_mac;
            r.conn_count = p.conn_count;
            case (p.msg_code)
                acmp_cr_pkg::MSG_CONNECT_TX: begin
                    tx_peer   = p.lsn_id;
                    tx_linked = 1'b1;
                    tx_count  = tx_count + 16'd1;
                    r.notify  = acmp_cr_pkg::NOTIFY_TX_CONNECT;
                end
                acmp_cr_pkg::MSG_DISCONNECT_TX: begin
                    tx_linked = 1'b0;
                    // floor at zero
                    if (tx_count != '0) tx_count = tx_count - 16'd1;
                    r.notify  = acmp_cr_pkg::NOTIFY_TX_DISCONNECT;
                end
                acmp_cr_pkg::MSG_CONNECT_RX: begin
                    rx_talker = p.tlk_id;
                    rx_stream = p.strm_id;
                    rx_mac    = p.dst_mac;
                    rx_linked = 1'b1;
                    rx_count  = rx_count + 16'd1;
                    r.notify  = acmp_cr_pkg::NOTIFY_RX_CONNECT;
                end
                acmp_cr_pkg::MSG_DISCONNECT_RX: begin
                    rx_linked = 1'b0;
                    if (rx_count != '0) rx_count = rx_count - 16'd1;
                    r.notify  = acmp_cr_pkg::NOTIFY_RX_DISCONNECT;
                end
                default: ;
            endcase
            if (p.msg_code == acmp_cr_pkg::MSG_CONNECT_TX
                || p.msg_code == acmp_cr_pkg::MSG_GET_TX_STATE) begin
                r.strm_id    = cfg_strm_id;
                r.dst_mac    = cfg_dst_mac;
                r.conn_count = tx_count;
            end else if (p.msg_code == acmp_cr_pkg::MSG_CONNECT_RX
                         || p.msg_code == acmp_cr_pkg::MSG_GET_RX_STATE) begin
                r.conn_count = rx_count;
            end
            r.msg_code      = p.msg_code + 4'd1;
            r.status        = acmp_cr_pkg::STATUS_SUCCESS;
            r.talker_on     = tx_linked;
            r.listener_on   = rx_linked;
            r.peer_listener = tx_peer;
            r.bound_talker  = rx_talker;
            r.bound_stream  = rx_stream;
            r.bound_mac     = rx_mac;
            resp_expected.push_back(r);
        end
    endtask

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    // sample both channels, predict and check
    always @(posedge i_clk) begin : watch_channels
        t_resp want;
        cycle_count  <= cycle_count + 1;
        in_accepted  <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_accepted <= i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            predict_response(cur_pdu);
            pdu_taken <= pdu_taken + 1;
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (resp_expected.size() == 0) begin
                mismatches++;
                $display("%0t: response with none expected, expected nothing, got type %h",
                         $time, o_resp_msg_code);
            end else begin
                want = resp_expected.pop_front();
                check_field("resp_msg_code", 64'(want.msg_code), 64'(o_resp_msg_code));
                check_field("resp_status", 64'(want.status), 64'(o_resp_status));
                check_field("resp_strm_id", want.strm_id, o_resp_strm_id);
                check_field("resp_dst_mac", 64'(want.dst_mac), 64'(o_resp_dst_mac));
                check_field("resp_conn_count", 64'(want.conn_count), 64'(o_resp_conn_count));
                check_field("notify_event", 64'(want.notify), 64'(o_notify_event));
                check_field("talker_is_connected", 64'(want.talker_on),
                            64'(o_talker_is_connected));
                check_field("listener_is_connected", 64'(want.listener_on),
                            64'(o_listener_is_connected));
                check_field("peer_lsn_id", want.peer_listener, o_peer_lsn_id);
                check_field("bound_tlk_id", want.bound_talker, o_bound_tlk_id);
                check_field("bound_strm_id", want.bound_stream, o_bound_strm_id);
                check_field("bound_dst_mac", 64'(want.bound_mac), 64'(o_bound_dst_mac));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // input driver: hold a stalled word, otherwise wait out the gap and load the next
    always @(negedge i_clk) begin : drive_pdus
        int unsigned wait_n;
        t_pdu        next_pdu;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!(i_in_valid && !in_accepted)) begin
            wait_n = i_in_valid ? draw_gap() : in_gap;
            if (wait_n == 0 && pdu_queue.size() != 0) begin
                next_pdu   = pdu_queue.pop_front();
                cur_pdu    <= next_pdu;
                i_in_valid <= 1'b1;
                in_gap     <= 0;
            end else begin
                i_in_valid <= 1'b0;
                in_gap     <= (wait_n != 0) ? wait_n - 1 : 0;
            end
        end
    end

    // response side: stall for a drawn number of cycles after each word taken
    always @(negedge i_clk) begin : drive_stall
        int unsigned hold_n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold    <= 0;
        end else begin
            hold_n = out_accepted ? draw_gap() : out_hold;
            if (hold_n != 0) begin
                i_out_stall <= 1'b1;
                out_hold    <= hold_n - 1;
            end else begin
                i_out_stall <= 1'b0;
                out_hold    <= 0;
            end
        end
    end

    task automatic write_reg(acmp_cr_pkg::t_cfg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            acmp_cr_pkg::CFG_ENTITY_MAC:  cfg_mac     = value[acmp_cr_pkg::MAC_W-1:0];
            acmp_cr_pkg::CFG_OWN_STRM_ID: cfg_strm_id = value;
            acmp_cr_pkg::CFG_OWN_DST_MAC: cfg_dst_mac = value[acmp_cr_pkg::MAC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and answered, then let the pipe empty
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pdu_taken != pdu_pushed || resp_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_pdu p;
        int   ph;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: entity id zero, own stream fields zero
        push_pdu(command_pdu(acmp_cr_pkg::MSG_GET_TX_STATE));
        push_pdu(command_pdu(acmp_cr_pkg::MSG_CONNECT_RX));
        wait_idle();

        write_reg(acmp_cr_pkg::CFG_ENTITY_MAC, rand64());
        write_reg(acmp_cr_pkg::CFG_OWN_STRM_ID, rand64());
        write_reg(acmp_cr_pkg::CFG_OWN_DST_MAC, rand64());

        // drop on wrong subtype and short frame, accept at the length boundary
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX);
        p.subtype = acmp_cr_pkg::ACMP_SUBTYPE + 8'd1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX);
        p.frm_bytes = acmp_cr_pkg::MIN_FRM_BYTES - 11'd1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX);
        p.frm_bytes = acmp_cr_pkg::MIN_FRM_BYTES; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX);
        p.frm_bytes = '1; p.lsn_id = '1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_GET_TX_STATE); p.subtype = '0; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_GET_TX_STATE); p.subtype = '1; push_pdu(p);
        // message types that are not commands
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX);
        p.msg_code = acmp_cr_pkg::MSG_CONNECT_TX + 4'd1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_GET_RX_STATE);
        p.msg_code = acmp_cr_pkg::MSG_GET_RX_STATE + 4'd1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_GET_RX_STATE);
        p.msg_code = acmp_cr_pkg::MSG_GET_RX_STATE + 4'd2; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_GET_RX_STATE); p.msg_code = '1; push_pdu(p);
        // foreign entity id
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_TX); p.tlk_id ^= 64'h1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_RX);
        p.lsn_id ^= 64'h8000_0000_0000_0000; push_pdu(p);
        // talker disconnects down past zero
        push_pdu(command_pdu(acmp_cr_pkg::MSG_GET_TX_STATE));
        p = command_pdu(acmp_cr_pkg::MSG_DISCONNECT_TX); p.conn_count = '1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_DISCONNECT_TX); p.conn_count = '0; push_pdu(p);
        push_pdu(command_pdu(acmp_cr_pkg::MSG_DISCONNECT_TX));
        // listener connects with extreme stream fields, then down past zero
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_RX);
        p.strm_id = '1; p.dst_mac = '1; p.tlk_id = '1; push_pdu(p);
        p = command_pdu(acmp_cr_pkg::MSG_CONNECT_RX);
        p.strm_id = '0; p.dst_mac = '0; p.tlk_id = '0; push_pdu(p);
        push_pdu(command_pdu(acmp_cr_pkg::MSG_GET_RX_STATE));
        repeat (4) push_pdu(command_pdu(acmp_cr_pkg::MSG_DISCONNECT_RX));
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(acmp_cr_pkg::CFG_ENTITY_MAC, '0);
                    write_reg(acmp_cr_pkg::CFG_OWN_STRM_ID, '0);
                    write_reg(acmp_cr_pkg::CFG_OWN_DST_MAC, '0);
                end
                1: begin
                    write_reg(acmp_cr_pkg::CFG_ENTITY_MAC, '1);
                    write_reg(acmp_cr_pkg::CFG_OWN_STRM_ID, '1);
                    write_reg(acmp_cr_pkg::CFG_OWN_DST_MAC, '1);
                    write_reg(CFG_UNUSED, rand64());
                end
                default: begin
                    write_reg(acmp_cr_pkg::CFG_ENTITY_MAC, rand64());
                    write_reg(acmp_cr_pkg::CFG_OWN_STRM_ID, rand64());
                    write_reg(acmp_cr_pkg::CFG_OWN_DST_MAC, rand64());
                end
            endcase
            // every third phase runs at full rate
            idle_on = (ph % 3 != 2);
            repeat (PHASE_PDUS) push_pdu(random_pdu());
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
